/* hw/rtl/ihp_pkg.sv */
`default_nettype none

package ihp_pkg;

  localparam int unsigned ITER_WIDTH_DEF = 16;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned CHAN_W         = 8;

  // Low counts (up to LOW_MAX) take the desaturated red rule
  localparam int unsigned LOW_MAX = 15;
  localparam int unsigned NIB_W   = 4;

  // Hue wraps at HUE_MOD; one sextant spans SEXT_SPAN degrees
  localparam int unsigned HUE_MOD   = 359;
  localparam int unsigned SEXT_SPAN = 60;
  localparam int unsigned HUE_W     = 9;
  localparam int unsigned K_W       = 6;

  // Byte-weighted residue sum: at most four bytes, each weight below HUE_MOD
  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned SUM_W     = 19;

  // Reciprocal of HUE_MOD: q = (sum * RECIP) >> RECIP_SHIFT is exact for sum < 2^19
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + HUE_MOD - 1)
                                                  / HUE_MOD);
  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam int unsigned Q_W    = PROD_W - RECIP_SHIFT;

  // 256^i mod 359 for byte i of the count
  localparam logic [HUE_W-1:0] BYTE_WEIGHT [MAX_BYTES] = '{9'd1, 9'd256, 9'd198, 9'd69};

  function automatic logic [CHAN_W-1:0] ramp_up(input logic [K_W-1:0] k);
    logic [9:0] p;
    p = 10'd17 * {4'd0, k};
    return p[9:2];
  endfunction

  function automatic logic [CHAN_W-1:0] ramp_down(input logic [K_W-1:0] k);
    logic [K_W-1:0] d;
    logic [9:0]     p;
    d = K_W'(SEXT_SPAN) - k;
    p = 10'd17 * {4'd0, d};
    return p[9:2];
  endfunction

  function automatic logic [COLOR_W-1:0] pack_rgb(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
    return {r, g, b};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/iteration_hsv_palette.sv */
// Iteration-count palette: turns one escape-iteration count into one packed
// RGB colour (red 23:16, green 15:8, blue 7:0).
//
// Input channel in_*: one request per pixel, count in in_tdata[ITER_WIDTH-1:0];
// padding bits above ITER_WIDTH are ignored. Output channel out_*: one colour
// per request, in request order.
//
// Four register stages: byte-residue sum, reciprocal multiply, remainder
// correction, sextant and ramp. Throughput is one request per cycle while
// out_tready stays high, set by the single 19x19 reciprocal multiplier in
// stage 2, which is fully pipelined.
//
// Reset (rst_n low, synchronous) empties all stages; out_tvalid drops in the
// cycle after. When the receiver holds out_tready low, the output register
// holds its colour and each earlier stage keeps filling as long as it has a
// free slot ahead, so in_tready falls only once all four stages are full.
`default_nettype none

module iteration_hsv_palette #(
  parameter int unsigned ITER_WIDTH = ihp_pkg::ITER_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  input  wire logic [((ITER_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // iter_count
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  output      logic [ihp_pkg::COLOR_W-1:0]          out_tdata   // color
);

  localparam int unsigned IN_BYTES   = (ITER_WIDTH + 7) / 8;
  localparam int unsigned IN_TDATA_W = IN_BYTES * 8;

  // Stage enables: a stage loads when it is empty or its contents move on
  logic en1, en2, en3, en4;

  // Stage 1: weighted byte sum congruent to the count mod 359
  logic                        v1_r;
  logic [ihp_pkg::SUM_W-1:0]   sum1_r, sum1_nxt;
  logic                        low1_r, low1_nxt;
  logic [ihp_pkg::NIB_W-1:0]   nib1_r;

  // Stage 2: quotient estimate
  logic                        v2_r;
  logic [ihp_pkg::SUM_W-1:0]   sum2_r;
  logic [ihp_pkg::Q_W-1:0]     q2_r, q2_nxt;
  logic                        low2_r;
  logic [ihp_pkg::NIB_W-1:0]   nib2_r;

  // Stage 3: hue
  logic                        v3_r;
  logic [ihp_pkg::HUE_W-1:0]   hue3_r, hue3_nxt;
  logic                        low3_r;
  logic [ihp_pkg::NIB_W-1:0]   nib3_r;

  // Stage 4: output register
  logic                        v4_r;
  logic [ihp_pkg::COLOR_W-1:0] color4_r, color4_nxt;

  logic [ITER_WIDTH-1:0]       count;
  logic [IN_TDATA_W-1:0]       count_pad;
  logic [ihp_pkg::PROD_W-1:0]  prod;
  logic [ihp_pkg::SUM_W-1:0]   qm;
  logic [ihp_pkg::SUM_W-1:0]   rem_full;
  logic [ihp_pkg::HUE_W:0]     rem;
  logic [ihp_pkg::K_W-1:0]     k;
  logic [ihp_pkg::CHAN_W-1:0]  lo_chan;

  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_tready  = en1;
  assign out_tvalid = v4_r;
  assign out_tdata  = color4_r;

  // Stage 1: split the count into bytes and weight each by 256^i mod 359
  assign count     = in_tdata[ITER_WIDTH-1:0];
  assign count_pad = IN_TDATA_W'(count);

  always_comb begin
    sum1_nxt = '0;
    for (int b = 0; b < IN_BYTES; b++) begin
      sum1_nxt = sum1_nxt + ihp_pkg::SUM_W'(count_pad[b*8 +: 8])
                          * ihp_pkg::SUM_W'(ihp_pkg::BYTE_WEIGHT[b]);
    end
    low1_nxt = (count <= ITER_WIDTH'(ihp_pkg::LOW_MAX));
  end

  // Stage 2: quotient by reciprocal multiply
  assign prod   = ihp_pkg::PROD_W'(sum1_r) * ihp_pkg::PROD_W'(ihp_pkg::RECIP);
  assign q2_nxt = prod[ihp_pkg::PROD_W-1:ihp_pkg::RECIP_SHIFT];

  // Stage 3: remainder, with one corrective subtract
  assign qm       = ihp_pkg::SUM_W'(q2_r) * ihp_pkg::SUM_W'(ihp_pkg::HUE_MOD);
  assign rem_full = sum2_r - qm;
  assign rem      = rem_full[ihp_pkg::HUE_W:0];

  always_comb begin
    if (rem >= (ihp_pkg::HUE_W + 1)'(ihp_pkg::HUE_MOD)) begin
      hue3_nxt = ihp_pkg::HUE_W'(rem - (ihp_pkg::HUE_W + 1)'(ihp_pkg::HUE_MOD));
    end else begin
      hue3_nxt = rem[ihp_pkg::HUE_W-1:0];
    end
  end

  // Stage 4: sextant, ramp and packing
  assign lo_chan = ihp_pkg::CHAN_W'(8'd17 * {4'd0, ihp_pkg::NIB_W'(ihp_pkg::LOW_MAX) - nib3_r});

  always_comb begin
    k          = '0;
    color4_nxt = '0;
    if (low3_r) begin
      color4_nxt = ihp_pkg::pack_rgb(8'hff, lo_chan, lo_chan);
    end else begin
      priority if (hue3_r < 9'd60) begin
        k          = ihp_pkg::K_W'(hue3_r);
        color4_nxt = ihp_pkg::pack_rgb(8'hff, ihp_pkg::ramp_up(k), 8'h00);
      end else if (hue3_r < 9'd120) begin
        k          = ihp_pkg::K_W'(hue3_r - 9'd60);
        color4_nxt = ihp_pkg::pack_rgb(ihp_pkg::ramp_down(k), 8'hff, 8'h00);
      end else if (hue3_r < 9'd180) begin
        k          = ihp_pkg::K_W'(hue3_r - 9'd120);
        color4_nxt = ihp_pkg::pack_rgb(8'h00, 8'hff, ihp_pkg::ramp_up(k));
      end else if (hue3_r < 9'd240) begin
        k          = ihp_pkg::K_W'(hue3_r - 9'd180);
        color4_nxt = ihp_pkg::pack_rgb(8'h00, ihp_pkg::ramp_down(k), 8'hff);
      end else if (hue3_r < 9'd300) begin
        k          = ihp_pkg::K_W'(hue3_r - 9'd240);
        color4_nxt = ihp_pkg::pack_rgb(ihp_pkg::ramp_up(k), 8'h00, 8'hff);
      end else begin
        k          = ihp_pkg::K_W'(hue3_r - 9'd300);
        color4_nxt = ihp_pkg::pack_rgb(8'hff, 8'h00, ihp_pkg::ramp_down(k));
      end
    end
  end

  // Valid bits: advance with the data, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Payload: load on enable, hold otherwise
  always_ff @(posedge clk) begin
    if (en1) begin
      sum1_r <= sum1_nxt;
      low1_r <= low1_nxt;
      nib1_r <= count[ihp_pkg::NIB_W-1:0];
    end
    if (en2) begin
      sum2_r <= sum1_r;
      q2_r   <= q2_nxt;
      low2_r <= low1_r;
      nib2_r <= nib1_r;
    end
    if (en3) begin
      hue3_r <= hue3_nxt;
      low3_r <= low2_r;
      nib3_r <= nib2_r;
    end
    if (en4) begin
      color4_r <= color4_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ihp_checker.sv */
`default_nettype none

module ihp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [ihp_pkg::COLOR_W-1:0]   out_tdata
);

  // Result held while the receiver stalls
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  // Empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Every palette colour has at least one channel at full scale
  a_one_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:16] == 8'hff || out_tdata[15:8] == 8'hff
                    || out_tdata[7:0] == 8'hff))
    else $error("colour with no full channel");

  // Either a grey-red (green equals blue) or a hue colour with at least one channel off
  a_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:8] == out_tdata[7:0] || out_tdata[23:16] == 8'h00
                    || out_tdata[15:8] == 8'h00 || out_tdata[7:0] == 8'h00))
    else $error("colour outside the palette");

endmodule

bind iteration_hsv_palette ihp_checker u_ihp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
